>>> sv/atte_pkg.sv
// ----------------------------------------------------------------------------
// atte_pkg
// shared types and constants of the text terminal engine
// ----------------------------------------------------------------------------
package atte_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 80;
  localparam int unsigned SCREEN_HEIGHT_DEF = 25;
  localparam int unsigned STORE_LINES_DEF   = 64;
  localparam int unsigned ESC_MAX_LEN_DEF   = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_FG = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_BG = 1'b1;
  localparam logic [2:0] DEFAULT_FG_RESET = 3'd7;
  localparam logic [2:0] DEFAULT_BG_RESET = 3'd0;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;

  typedef enum logic [2:0] {
    CL_NUL,
    CL_BS,
    CL_TAB,
    CL_LF,
    CL_VTFF,
    CL_CR,
    CL_ESC,
    CL_PRINT
  } atte_class_e;

  typedef struct packed {
    logic        func;
    atte_class_e cls;
    logic [7:0]  char_byte;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } atte_item_t;

  typedef struct packed {
    logic       valid;
    atte_item_t item;
  } atte_queue_t;

  typedef struct packed {
    logic clearing;
  } atte_status_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        cursor_visible;
    logic [5:0]  top_line;
    logic        in_escape;
    logic [15:0] cell_value;
  } atte_result_t;

endpackage

>>> sv/ansi_text_terminal_engine_unit.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine_unit
// text terminal with escape sequence decoding and a circular cell store
// ----------------------------------------------------------------------------
// after reset the cell store is cleared one cell a cycle, all STORE_LINES *
// SCREEN_WIDTH cells, with full held high; configuration writes are taken
// throughout. a word then passes from acceptance to the result register
// through queue hand-over, execute step and result hand-over, with a
// registered store read added for a cell read; the back end takes no new word
// until the last one's result is handed over. a scroll or an erase writes one
// cell a cycle through the single store port, up to SCREEN_WIDTH *
// SCREEN_HEIGHT cells for a whole-screen erase.
module ansi_text_terminal_engine_unit import atte_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned STORE_LINES   = STORE_LINES_DEF,
  parameter int unsigned ESC_MAX_LEN   = ESC_MAX_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [2:0]             cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic                   func_i,
  input  logic [7:0]             char_byte_i,
  input  logic [4:0]             read_row_i,
  input  logic [6:0]             read_col_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [6:0]             cursor_col_o,
  output logic [4:0]             cursor_row_o,
  output logic                   cursor_visible_o,
  output logic [5:0]             top_line_o,
  output logic                   in_escape_o,
  output logic [15:0]            cell_value_o
);

  logic [2:0]   default_fg_q, default_bg_q;
  atte_queue_t  queue;
  logic         q_pop;
  atte_status_t status;
  logic         res_valid, res_ready;
  atte_result_t res;
  logic         out_valid_q, out_valid_d;
  atte_result_t out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_fg_q <= DEFAULT_FG_RESET;
      default_bg_q <= DEFAULT_BG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_FG: default_fg_q <= cfg_data_i;
        CFG_DEFAULT_BG: default_bg_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  atte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .char_byte_i (char_byte_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .status_i    (status),
    .q_o         (queue),
    .q_pop_i     (q_pop)
  );

  atte_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .STORE_LINES   (STORE_LINES),
    .ESC_MAX_LEN   (ESC_MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .default_fg_i (default_fg_q),
    .default_bg_i (default_bg_q),
    .q_i          (queue),
    .q_pop_o      (q_pop),
    .status_o     (status),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // result register, refilled in the cycle its word is taken
  assign res_ready = !out_valid_q || pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign empty            = !out_valid_q;
  assign cursor_col_o     = out_q.cursor_col;
  assign cursor_row_o     = out_q.cursor_row;
  assign cursor_visible_o = out_q.cursor_visible;
  assign top_line_o       = out_q.top_line;
  assign in_escape_o      = out_q.in_escape;
  assign cell_value_o     = out_q.cell_value;

endmodule

>>> sv/atte_ram.sv
// ----------------------------------------------------------------------------
// atte_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module atte_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

>>> sv/atte_front.sv
// ----------------------------------------------------------------------------
// atte_front
// input side: takes words, classifies bytes and queues them for the back end
// ----------------------------------------------------------------------------
module atte_front import atte_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic         func_i,
  input  logic [7:0]   char_byte_i,
  input  logic [4:0]   read_row_i,
  input  logic [6:0]   read_col_i,
  input  atte_status_t status_i,
  output atte_queue_t  q_o,
  input  logic         q_pop_i
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  atte_item_t      entries_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  atte_item_t      item_new;
  logic            accept;
  logic            take;

  always_comb begin
    item_new.func      = func_i;
    item_new.char_byte = char_byte_i;
    item_new.read_row  = read_row_i;
    item_new.read_col  = read_col_i;
    unique case (char_byte_i)
      CH_NUL:        item_new.cls = CL_NUL;
      CH_BS:         item_new.cls = CL_BS;
      CH_TAB:        item_new.cls = CL_TAB;
      CH_LF:         item_new.cls = CL_LF;
      CH_VT, CH_FF:  item_new.cls = CL_VTFF;
      CH_CR:         item_new.cls = CL_CR;
      CH_ESC:        item_new.cls = CL_ESC;
      default:       item_new.cls = CL_PRINT;
    endcase
  end

  assign full   = (count_q == CNTW'(QUEUE_DEPTH)) || status_i.clearing;
  assign accept = push && !full;
  assign take   = q_pop_i && (count_q != '0);

  assign q_o.valid = (count_q != '0);
  assign q_o.item  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (accept && !take) begin
      count_d = count_q + 1'b1;
    end else if (take && !accept) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entries_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

>>> sv/atte_back.sv
// ----------------------------------------------------------------------------
// atte_back
// execution side: cursor, escape parser, colour state and cell store sweeps
// ----------------------------------------------------------------------------
module atte_back import atte_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned STORE_LINES   = STORE_LINES_DEF,
  parameter int unsigned ESC_MAX_LEN   = ESC_MAX_LEN_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [2:0]   default_fg_i,
  input  logic [2:0]   default_bg_i,
  input  atte_queue_t  q_i,
  output logic         q_pop_o,
  output atte_status_t status_o,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output atte_result_t res_o
);

  localparam int unsigned DEPTH = STORE_LINES * SCREEN_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(STORE_LINES);
  localparam logic [7:0]  W8    = 8'(SCREEN_WIDTH);
  localparam logic [5:0]  H6    = 6'(SCREEN_HEIGHT);
  localparam logic [6:0]  WMAX  = 7'(SCREEN_WIDTH - 1);
  localparam logic [4:0]  HMAX  = 5'(SCREEN_HEIGHT - 1);
  localparam logic [5:0]  EMAX  = 6'(ESC_MAX_LEN);

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_DIG0     = 8'h30;
  localparam logic [7:0] CH_DIG2     = 8'h32;
  localparam logic [7:0] CH_DIG5     = 8'h35;
  localparam logic [7:0] CH_DIG9     = 8'h39;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CMD_A = 8'h41;
  localparam logic [7:0] CMD_B = 8'h42;
  localparam logic [7:0] CMD_C = 8'h43;
  localparam logic [7:0] CMD_D = 8'h44;
  localparam logic [7:0] CMD_E = 8'h45;
  localparam logic [7:0] CMD_F = 8'h46;
  localparam logic [7:0] CMD_G = 8'h47;
  localparam logic [7:0] CMD_H = 8'h48;
  localparam logic [7:0] CMD_J = 8'h4A;
  localparam logic [7:0] CMD_K = 8'h4B;
  localparam logic [7:0] CMD_LF = 8'h66;
  localparam logic [7:0] CMD_LH = 8'h68;
  localparam logic [7:0] CMD_LL = 8'h6C;
  localparam logic [7:0] CMD_LM = 8'h6D;
  localparam logic [7:0] CMD_LS = 8'h73;
  localparam logic [7:0] CMD_LU = 8'h75;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MT_START,
    MT_QUEST,
    MT_TWO,
    MT_MATCH,
    MT_FAIL
  } match_e;

  state_e          state_q, state_d;
  match_e          match_q, match_d;
  atte_item_t      item_q, item_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [6:0]      cur_col_q, cur_col_d, saved_col_q, saved_col_d;
  logic [4:0]      cur_row_q, cur_row_d, saved_row_q, saved_row_d;
  logic [LW-1:0]   scroll_q, scroll_d;
  logic [7:0]      colour_q, colour_d, pend_q, pend_d;
  logic            show_q, show_d, esc_q, esc_d;
  logic [5:0]      esc_cnt_q, esc_cnt_d;
  logic [15:0]     pfirst_q, pfirst_d, psecond_q, psecond_d, part_q, part_d;
  logic [3:0]      pflags_q, pflags_d;
  logic [15:0]     cell_q, cell_d;
  logic [6:0]      fill_col_q, fill_col_d, end_col_q, end_col_d;
  logic [4:0]      fill_row_q, fill_row_d, end_row_q, end_row_d;

  logic            ram_en, ram_we;
  logic [AW-1:0]   ram_addr;
  logic [15:0]     ram_wdata, ram_rdata;

  logic [7:0]      b;
  logic            fin, ok;
  logic [15:0]     n;
  logic [16:0]     sum;
  logic [7:0]      col_t;
  logic [5:0]      row_t;
  logic [1:0]      parts;
  logic [3:0]      dig;
  logic [LW+5:0]   top_ext;

  function automatic logic [AW-1:0] cell_addr(logic [LW-1:0] top, logic [4:0] row,
                                              logic [6:0] col);
    logic [LW:0] line;
    line = {1'b0, top} + (LW+1)'(row);
    if (line >= (LW+1)'(STORE_LINES)) begin
      line = line - (LW+1)'(STORE_LINES);
    end
    return AW'(32'(line) * 32'(SCREEN_WIDTH) + 32'(col));
  endfunction

  function automatic logic [2:0] colour_map(logic [2:0] i);
    logic [2:0] r;
    unique case (i)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sgr(logic [7:0] attr, logic [15:0] v,
                                     logic [2:0] dfg, logic [2:0] dbg);
    logic [3:0] fg;
    logic [3:0] bg;
    fg = attr[3:0];
    bg = attr[7:4];
    priority if (v == 16'd0) begin
      fg = {1'b0, dfg};
      bg = {1'b0, dbg};
    end else if (v >= 16'd30 && v <= 16'd37) begin
      fg = {1'b0, colour_map(3'(v - 16'd30))};
    end else if (v == 16'd39) begin
      fg = {1'b0, dfg};
    end else if (v >= 16'd40 && v <= 16'd47) begin
      bg = {1'b0, colour_map(3'(v - 16'd40))};
    end else if (v == 16'd49) begin
      bg = {1'b0, dbg};
    end else if (v >= 16'd90 && v <= 16'd97) begin
      fg = {1'b1, colour_map(3'(v - 16'd90))};
    end else if (v == 16'd99) begin
      fg = {1'b1, dfg};
    end else if (v >= 16'd100 && v <= 16'd107) begin
      bg = {1'b1, colour_map(3'(v - 16'd100))};
    end else if (v == 16'd109) begin
      bg = {1'b1, dbg};
    end
    return {bg, fg};
  endfunction

  function automatic logic [15:0] acc(logic [15:0] v, logic [3:0] d);
    logic [19:0] r;
    r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + 20'(d);
    return (r > 20'hFFFF) ? 16'hFFFF : r[15:0];
  endfunction

  atte_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign b     = item_q.char_byte;
  assign fin   = (b > 8'h40) && (b < 8'h7E);
  assign ok    = fin || (b == CH_SEMI) || (b == CH_QUEST) || (b >= CH_DIG0 && b <= CH_DIG9);
  assign parts = pflags_q[2:1];
  assign dig   = 4'(b - CH_DIG0);

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign top_ext           = (LW+6)'(scroll_q);

  assign res_valid_o          = (state_q == ST_EMIT);
  assign res_o.cursor_col     = cur_col_q;
  assign res_o.cursor_row     = cur_row_q;
  assign res_o.cursor_visible = show_q;
  assign res_o.top_line       = top_ext[5:0];
  assign res_o.in_escape      = esc_q;
  assign res_o.cell_value     = cell_q;

  always_comb begin
    state_d     = state_q;
    match_d     = match_q;
    item_d      = item_q;
    clr_cnt_d   = clr_cnt_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    saved_col_d = saved_col_q;
    saved_row_d = saved_row_q;
    scroll_d    = scroll_q;
    colour_d    = colour_q;
    pend_d      = pend_q;
    show_d      = show_q;
    esc_d       = esc_q;
    esc_cnt_d   = esc_cnt_q;
    pfirst_d    = pfirst_q;
    psecond_d   = psecond_q;
    part_d      = part_q;
    pflags_d    = pflags_q;
    cell_d      = cell_q;
    fill_col_d  = fill_col_q;
    fill_row_d  = fill_row_q;
    end_col_d   = end_col_q;
    end_row_d   = end_row_q;
    q_pop_o     = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    n           = '0;
    sum         = '0;
    col_t       = {1'b0, cur_col_q};
    row_t       = {1'b0, cur_row_q};

    unique case (state_q)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_cnt_q;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          item_d  = q_i.item;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_EMIT;
        cell_d  = '0;
        if (item_q.func) begin
          if ({1'b0, item_q.read_row} < H6 && {1'b0, item_q.read_col} < W8) begin
            ram_en   = 1'b1;
            ram_addr = cell_addr(scroll_q, item_q.read_row, item_q.read_col);
            state_d  = ST_READ;
          end
        end else if (esc_q) begin
          esc_cnt_d = (esc_cnt_q == 6'h3F) ? esc_cnt_q : esc_cnt_q + 1'b1;
          if (esc_cnt_q == '0) begin
            if (b != CH_LBRACKET) begin
              esc_d = 1'b0;
            end
          end else if (esc_cnt_q >= EMAX || !ok) begin
            esc_d = 1'b0;
          end else if (fin) begin
            esc_d = 1'b0;
            n     = pflags_q[0] ? pfirst_q : 16'd1;
            unique case (b)
              CMD_A, CMD_F: begin
                cur_row_d = (n >= 16'(cur_row_q)) ? '0 : cur_row_q - 5'(n);
                if (b == CMD_F) begin
                  cur_col_d = '0;
                end
              end
              CMD_B, CMD_E: begin
                sum       = 17'(cur_row_q) + 17'(n);
                cur_row_d = (sum >= 17'(SCREEN_HEIGHT)) ? HMAX : 5'(sum);
                if (b == CMD_E) begin
                  cur_col_d = '0;
                end
              end
              CMD_C: begin
                sum       = 17'(cur_col_q) + 17'(n);
                cur_col_d = (sum >= 17'(SCREEN_WIDTH)) ? WMAX : 7'(sum);
              end
              CMD_D: begin
                cur_col_d = (n >= 16'(cur_col_q)) ? '0 : cur_col_q - 7'(n);
              end
              CMD_G: begin
                cur_col_d = (n == '0) ? '0 :
                            (n >= 16'(SCREEN_WIDTH)) ? WMAX : 7'(n - 16'd1);
              end
              CMD_H, CMD_LF: begin
                cur_row_d = (pfirst_q == '0) ? '0 :
                            (pfirst_q >= 16'(SCREEN_HEIGHT)) ? HMAX : 5'(pfirst_q - 16'd1);
                cur_col_d = (psecond_q == '0) ? '0 :
                            (psecond_q >= 16'(SCREEN_WIDTH)) ? WMAX : 7'(psecond_q - 16'd1);
              end
              CMD_J, CMD_K: begin
                n = pflags_q[0] ? pfirst_q : 16'd0;
                if (n <= 16'd2) begin
                  state_d    = ST_FILL;
                  fill_row_d = cur_row_q;
                  fill_col_d = '0;
                  end_row_d  = cur_row_q;
                  end_col_d  = WMAX;
                  if (n == 16'd0) begin
                    fill_col_d = cur_col_q;
                    if (b == CMD_J) begin
                      end_row_d = HMAX;
                    end
                  end else if (n == 16'd1) begin
                    end_col_d = cur_col_q;
                    if (b == CMD_J) begin
                      fill_row_d = '0;
                    end
                  end else if (b == CMD_J) begin
                    fill_row_d = '0;
                    end_row_d  = HMAX;
                  end
                end
              end
              CMD_LM: colour_d = sgr(pend_q, part_q, default_fg_i, default_bg_i);
              CMD_LS: begin
                saved_col_d = cur_col_q;
                saved_row_d = cur_row_q;
              end
              CMD_LU: begin
                cur_col_d = saved_col_q;
                cur_row_d = saved_row_q;
              end
              CMD_LL: begin
                if (match_q == MT_MATCH) begin
                  show_d = 1'b0;
                end
              end
              CMD_LH: begin
                if (match_q == MT_MATCH) begin
                  show_d = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end else begin
            priority if (match_q == MT_START && b == CH_QUEST) begin
              match_d = MT_QUEST;
            end else if (match_q == MT_QUEST && b == CH_DIG2) begin
              match_d = MT_TWO;
            end else if (match_q == MT_TWO && b == CH_DIG5) begin
              match_d = MT_MATCH;
            end else begin
              match_d = MT_FAIL;
            end
            pflags_d[0] = 1'b1;
            if (b >= CH_DIG0 && b <= CH_DIG9) begin
              if (parts == 2'd0) begin
                pfirst_d = acc(pfirst_q, dig);
              end else if (parts == 2'd1) begin
                psecond_d = acc(psecond_q, dig);
              end
              part_d = acc(part_q, dig);
            end else if (b == CH_SEMI) begin
              pend_d        = sgr(pend_q, part_q, default_fg_i, default_bg_i);
              part_d        = '0;
              pflags_d[2:1] = (parts == 2'd3) ? parts : parts + 1'b1;
            end
          end
        end else begin
          unique case (item_q.cls)
            CL_NUL: begin
            end
            CL_BS: begin
              if (col_t != '0) begin
                col_t = col_t - 1'b1;
              end
            end
            CL_TAB: begin
              col_t = (col_t + 8'd8) & 8'hF8;
              if (col_t >= W8) begin
                col_t = {1'b0, WMAX};
              end
            end
            CL_LF: begin
              col_t = '0;
              row_t = row_t + 1'b1;
            end
            CL_VTFF: row_t = row_t + 1'b1;
            CL_CR:   col_t = '0;
            CL_ESC: begin
              esc_d     = 1'b1;
              esc_cnt_d = '0;
              pfirst_d  = '0;
              psecond_d = '0;
              pflags_d  = '0;
              part_d    = '0;
              match_d   = MT_START;
              pend_d    = colour_q;
            end
            CL_PRINT: begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = cell_addr(scroll_q, cur_row_q, cur_col_q);
              ram_wdata = {colour_q, b};
              col_t     = col_t + 1'b1;
            end
          endcase
          if (col_t >= W8) begin
            col_t = '0;
            row_t = row_t + 1'b1;
          end
          if (row_t >= H6) begin
            row_t      = {1'b0, HMAX};
            scroll_d   = (scroll_q == LW'(STORE_LINES - 1)) ? '0 : scroll_q + 1'b1;
            state_d    = ST_FILL;
            fill_row_d = HMAX;
            fill_col_d = '0;
            end_row_d  = HMAX;
            end_col_d  = WMAX;
          end
          cur_col_d = col_t[6:0];
          cur_row_d = row_t[4:0];
        end
      end

      ST_READ: begin
        cell_d  = ram_rdata;
        state_d = ST_EMIT;
      end

      ST_FILL: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = cell_addr(scroll_q, fill_row_q, fill_col_q);
        ram_wdata = {colour_q, CH_SPACE};
        if (fill_row_q == end_row_q && fill_col_q == end_col_q) begin
          state_d = ST_EMIT;
        end else if (fill_col_q == WMAX) begin
          fill_col_d = '0;
          fill_row_d = fill_row_q + 1'b1;
        end else begin
          fill_col_d = fill_col_q + 1'b1;
        end
      end

      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      match_q     <= MT_START;
      clr_cnt_q   <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      saved_col_q <= '0;
      saved_row_q <= '0;
      scroll_q    <= '0;
      colour_q    <= {1'b0, DEFAULT_BG_RESET, 1'b0, DEFAULT_FG_RESET};
      pend_q      <= {1'b0, DEFAULT_BG_RESET, 1'b0, DEFAULT_FG_RESET};
      show_q      <= 1'b0;
      esc_q       <= 1'b0;
      esc_cnt_q   <= '0;
      pfirst_q    <= '0;
      psecond_q   <= '0;
      part_q      <= '0;
      pflags_q    <= '0;
      fill_col_q  <= '0;
      fill_row_q  <= '0;
      end_col_q   <= '0;
      end_row_q   <= '0;
    end else begin
      state_q     <= state_d;
      match_q     <= match_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      saved_col_q <= saved_col_d;
      saved_row_q <= saved_row_d;
      scroll_q    <= scroll_d;
      colour_q    <= colour_d;
      pend_q      <= pend_d;
      show_q      <= show_d;
      esc_q       <= esc_d;
      esc_cnt_q   <= esc_cnt_d;
      pfirst_q    <= pfirst_d;
      psecond_q   <= psecond_d;
      part_q      <= part_d;
      pflags_q    <= pflags_d;
      fill_col_q  <= fill_col_d;
      fill_row_q  <= fill_row_d;
      end_col_q   <= end_col_d;
      end_row_q   <= end_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cell_q <= cell_d;
  end

  // cursor never leaves the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> ({1'b0, cur_row_q} < H6) && ({1'b0, cur_col_q} < W8))
    else $error("cursor outside screen");

  // no store write while read data is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !ram_we)
    else $error("cell write during read");

  // sweeps stay within their end row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> fill_row_q <= end_row_q)
    else $error("fill sweep overran");

  // the clearing pass only follows reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_CLEAR |=> state_q != ST_CLEAR)
    else $error("clearing pass restarted");

  // a result is offered until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(cell_q))
    else $error("result dropped");

endmodule

>>> tb/ansi_text_terminal_engine_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine_unit_test
// self-checking bench of the text terminal engine: a scoreboard class keeps
// its own screen model, predicts every result word and compares it field by
// field; bursty stimulus, random result stalls and a long hold-off, over
// several default colour settings
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine_unit_test;
  import atte_pkg::*;

  localparam int unsigned SW = SCREEN_WIDTH_DEF;
  localparam int unsigned SH = SCREEN_HEIGHT_DEF;
  localparam int unsigned SL = STORE_LINES_DEF;
  localparam int unsigned EL = ESC_MAX_LEN_DEF;

  class terminal_scoreboard;
    logic [15:0]  cells [SW*SL];
    int unsigned  dfg, dbg, col, row, scol, srow, top, attr, shown, esc, ecount;
    int unsigned  pfirst, psecond, pflags, pend, part, match;
    atte_result_t expected_q [$];
    int unsigned  errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      dfg = DEFAULT_FG_RESET; dbg = DEFAULT_BG_RESET;
      col = 0; row = 0; scol = 0; srow = 0; top = 0; attr = 8'h07;
      shown = 0; esc = 0; ecount = 0; pfirst = 0; psecond = 0; pflags = 0;
      pend = attr; part = 0; match = 0; errors = 0;
    endfunction

    function int unsigned cell_at(int unsigned c, int unsigned r);
      return ((top + r) % SL) * SW + (c % SW);
    endfunction

    function void fill_row(int unsigned r, int unsigned from, int unsigned to);
      for (int unsigned c = from; c < to && c < SW; c++)
        cells[cell_at(c, r)] = {attr[7:0], 8'h20};
    endfunction

    function int unsigned vga(int unsigned i);
      logic [3:0] map [8] = '{0, 4, 2, 6, 1, 5, 3, 7};
      return map[i];
    endfunction

    function int unsigned colour_step(int unsigned a, int unsigned n);
      int unsigned fg, bg;
      fg = a & 15; bg = (a >> 4) & 15;
      if (n == 0) begin fg = dfg; bg = dbg; end
      else if (n >= 30 && n <= 37) fg = vga(n - 30);
      else if (n == 39) fg = dfg;
      else if (n >= 40 && n <= 47) bg = vga(n - 40);
      else if (n == 49) bg = dbg;
      else if (n >= 90 && n <= 97) fg = vga(n - 90) | 8;
      else if (n == 99) fg = dfg | 8;
      else if (n >= 100 && n <= 107) bg = vga(n - 100) | 8;
      else if (n == 109) bg = dbg | 8;
      return (bg << 4) | fg;
    endfunction

    function int unsigned add_digit(int unsigned v, int unsigned d);
      longint unsigned r;
      r = longint'(v) * 10 + d;
      return (r > 65535) ? 65535 : int'(r);
    endfunction

    function int unsigned clamp1(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void run_command(byte unsigned cmd);
      bit          blank;
      int unsigned n;
      blank = (pflags & 1) == 0;
      n = blank ? 1 : pfirst;
      case (cmd)
        "A", "F": begin
          row = (n >= row) ? 0 : row - n;
          if (cmd == "F") col = 0;
        end
        "B", "E": begin
          row = (row + n >= SH) ? SH - 1 : row + n;
          if (cmd == "E") col = 0;
        end
        "C": col = (col + n >= SW) ? SW - 1 : col + n;
        "D": col = (n >= col) ? 0 : col - n;
        "G": col = clamp1(n, SW) - 1;
        "H", "f": begin
          row = clamp1(pfirst, SH) - 1;
          col = clamp1(psecond, SW) - 1;
        end
        "J", "K": begin
          n = blank ? 0 : pfirst;
          if (n == 0) begin
            fill_row(row, col, SW);
            if (cmd == "J") for (int unsigned r = row + 1; r < SH; r++) fill_row(r, 0, SW);
          end else if (n == 1) begin
            fill_row(row, 0, col + 1);
            if (cmd == "J") for (int unsigned r = 0; r < row; r++) fill_row(r, 0, SW);
          end else if (n == 2) begin
            if (cmd == "J") for (int unsigned r = 0; r < SH; r++) fill_row(r, 0, SW);
            else fill_row(row, 0, SW);
          end
        end
        "m": attr = colour_step(pend, part);
        "s": begin scol = col; srow = row; end
        "u": begin col = scol; row = srow; end
        "l": if (match == 3) shown = 0;
        "h": if (match == 3) shown = 1;
        default: ;
      endcase
    endfunction

    function void take_param(byte unsigned b);
      int unsigned parts;
      parts = (pflags >> 1) & 3;
      if (match == 0 && b == "?") match = 1;
      else if (match == 1 && b == "2") match = 2;
      else if (match == 2 && b == "5") match = 3;
      else match = 4;
      pflags |= 1;
      if (b >= "0" && b <= "9") begin
        if (parts == 0) pfirst = add_digit(pfirst, b - "0");
        else if (parts == 1) psecond = add_digit(psecond, b - "0");
        part = add_digit(part, b - "0");
      end else if (b == ";") begin
        pend = colour_step(pend, part);
        part = 0;
        if (parts < 3) parts++;
        pflags = (pflags & 1) | (parts << 1);
      end
    endfunction

    function void terminal_byte(byte unsigned b);
      bit fin, ok;
      if (esc) begin
        if (ecount == 0) begin
          if (b != "[") esc = 0;
        end else begin
          fin = b > 8'h40 && b < 8'h7E;
          ok = fin || b == ";" || b == "?" || (b >= "0" && b <= "9");
          if (ecount >= EL || !ok) esc = 0;
          else if (fin) begin esc = 0; run_command(b); end
          else take_param(b);
        end
        if (ecount < 255) ecount++;
      end else begin
        case (b)
          CH_NUL: ;
          CH_BS: if (col != 0) col--;
          CH_TAB: begin
            col = (col + 8) & ~32'd7;
            if (col >= SW) col = SW - 1;
          end
          CH_LF: begin col = 0; row++; end
          CH_VT, CH_FF: row++;
          CH_CR: col = 0;
          CH_ESC: begin
            esc = 1; ecount = 0; pfirst = 0; psecond = 0; pflags = 0;
            part = 0; match = 0; pend = attr;
          end
          default: begin
            cells[cell_at(col, row)] = {attr[7:0], b};
            col++;
          end
        endcase
      end
      if (col >= SW) begin col = 0; row++; end
      if (row >= SH) begin
        row = SH - 1;
        top = (top + 1) % SL;
        fill_row(SH - 1, 0, SW);
      end
    endfunction

    function void set_default(logic [CFG_INDEX_W-1:0] idx, logic [2:0] v);
      if (idx == CFG_DEFAULT_FG) dfg = v; else dbg = v;
    endfunction

    function void note_word(bit f, byte unsigned b, int unsigned r, int unsigned c);
      atte_result_t e;
      int unsigned  cv;
      cv = 0;
      if (!f) terminal_byte(b);
      else if (r < SH && c < SW) cv = cells[cell_at(c, r)];
      e.cursor_col = 7'(col); e.cursor_row = 5'(row); e.cursor_visible = 1'(shown);
      e.top_line = 6'(top); e.in_escape = 1'(esc); e.cell_value = 16'(cv);
      expected_q.push_back(e);
    endfunction

    function void check_word(atte_result_t got);
      atte_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: col %0d/%0d row %0d/%0d vis %0d/%0d top %0d/%0d esc %0d/%0d cell %h/%h",
                   e.cursor_col, got.cursor_col, e.cursor_row, got.cursor_row,
                   e.cursor_visible, got.cursor_visible, e.top_line, got.top_line,
                   e.in_escape, got.in_escape, e.cell_value, got.cell_value);
      end
    endfunction
  endclass

  logic                   clk_i, rst_ni;
  logic                   cfg_valid_i, cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [2:0]             cfg_data_i;
  logic                   push, full, empty, pop;
  logic                   func_i;
  logic [7:0]             char_byte_i;
  logic [4:0]             read_row_i;
  logic [6:0]             read_col_i;
  logic [6:0]             cursor_col_o;
  logic [4:0]             cursor_row_o;
  logic                   cursor_visible_o, in_escape_o;
  logic [5:0]             top_line_o;
  logic [15:0]            cell_value_o;

  ansi_text_terminal_engine_unit i_dut (.*);

  terminal_scoreboard screen_sb = new();
  int unsigned        burst_left = 0;
  int unsigned        words_sent = 0;
  int unsigned        words_popped = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    atte_result_t got;
    if (rst_ni && pop && !empty) begin
      got = '{cursor_col_o, cursor_row_o, cursor_visible_o, top_line_o, in_escape_o,
              cell_value_o};
      screen_sb.check_word(got);
      words_popped++;
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int unsigned stall_pct, hold_cnt;
    bit          held;
    stall_pct = 0; hold_cnt = 0; held = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 127) == 0) stall_pct = $urandom_range(0, 2) * 35;
      if (hold_cnt != 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (!held && words_popped >= 500) begin
        held = 1; hold_cnt = 400;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic put_word(bit f, byte unsigned b, bit [4:0] r, bit [6:0] c);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    func_i <= f; char_byte_i <= b; read_row_i <= r; read_col_i <= c;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    screen_sb.note_word(f, b, r, c);
    burst_left--;
    words_sent++;
  endtask

  task automatic put_byte(byte unsigned b);
    put_word(1'b0, b, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic write_defaults(logic [2:0] fg, logic [2:0] bg);
    cfg_valid_i <= 1'b1; cfg_index_i <= CFG_DEFAULT_FG; cfg_data_i <= fg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    screen_sb.set_default(CFG_DEFAULT_FG, fg);
    cfg_index_i <= CFG_DEFAULT_BG; cfg_data_i <= bg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    screen_sb.set_default(CFG_DEFAULT_BG, bg);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (screen_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic put_number();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) put_text($sformatf("%0d", $urandom_range(0, 9)));
    else if (pick < 8) put_text($sformatf("%0d", $urandom_range(0, 110)));
    else if (pick < 9) put_text("99999");
    else put_text($sformatf("%0d", $urandom_range(0, 200)));
  endtask

  task automatic put_sequence();
    string       finals;
    int unsigned kind, nums;
    finals = "ABCDEFGHfmmmsulhKKGHABCD";
    put_byte(CH_ESC);
    if ($urandom_range(0, 19) == 0) begin
      put_byte(8'($urandom_range(0, 255)));
      return;
    end
    put_byte("[");
    kind = $urandom_range(0, 19);
    if (kind < 4) put_text("?25");
    else if (kind == 4) begin
      put_byte("?");
      put_number();
    end else if (kind == 5) begin
      repeat ($urandom_range(12, 20)) put_byte(8'("0" + $urandom_range(0, 9)));
    end else begin
      nums = $urandom_range(0, 3);
      for (int i = 0; i < nums; i++) begin
        if (i != 0) put_byte(";");
        if ($urandom_range(0, 5) != 0) put_number();
      end
    end
    kind = $urandom_range(0, 39);
    if (kind == 0) put_byte("J");
    else if (kind < 3) put_byte(8'($urandom_range(0, 255)));
    else if (kind < 5) put_byte(8'($urandom_range(8'h41, 8'h7D)));
    else put_byte(finals[$urandom_range(0, finals.len() - 1)]);
  endtask

  task automatic random_phase(int unsigned count);
    byte unsigned ctl [8] = '{CH_NUL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, 8'h01};
    int unsigned  stop, pick;
    stop = words_sent + count;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) put_byte(8'($urandom_range(8'h20, 8'hFF)));
      else if (pick < 35) put_byte(8'($urandom_range(0, 255)));
      else if (pick < 48) put_byte(ctl[$urandom_range(0, 7)]);
      else if (pick < 68) begin
        if ($urandom_range(0, 7) == 0)
          put_word(1'b1, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                   7'($urandom_range(0, 127)));
        else
          put_word(1'b1, 8'($urandom_range(0, 255)), 5'($urandom_range(0, SH - 1)),
                   7'($urandom_range(0, SW - 1)));
      end else put_sequence();
    end
  endtask

  initial begin
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    push = 1'b0; func_i = 1'b0; char_byte_i = '0; read_row_i = '0; read_col_i = '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    write_defaults(3'd7, 3'd0);
    put_text("A");
    put_byte(8'hFF);
    put_byte(CH_NUL);
    put_byte(CH_BS);
    put_byte(CH_TAB);
    put_byte(CH_LF);
    put_byte(CH_VT);
    put_byte(CH_CR);
    put_byte(CH_ESC);
    put_text("[25;80H");
    put_byte(CH_FF);
    put_word(1'b1, 8'h00, 5'd0, 7'd0);
    put_word(1'b1, 8'hFF, 5'd24, 7'd79);
    put_word(1'b1, 8'h55, 5'd31, 7'd127);
    random_phase(450);
    drain();
    write_defaults(3'd0, 3'd7);
    random_phase(450);
    drain();
    write_defaults(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    random_phase(450);
    drain();
    write_defaults(3'd0, 3'd0);
    random_phase(450);
    drain();
    if (screen_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
